// ----- hdl/utf8a_pkg.sv -----
// Shared types and constants for the UTF-8 to ASCII filter.
// Used by utf8a_decode, utf8a_emit and utf8_to_ascii_filter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8a_pkg;

	localparam int CNT_W = 10;

	localparam logic [7:0] LEAD_PUNCT   = 8'hE2;
	localparam logic [7:0] MID_PUNCT    = 8'h80;
	localparam logic [7:0] TAIL_ELLIPS  = 8'hA6;
	localparam logic [7:0] TAIL_EN      = 8'h93;
	localparam logic [7:0] TAIL_EM      = 8'h94;
	localparam logic [7:0] TAIL_LQUOTE  = 8'h98;
	localparam logic [7:0] TAIL_RQUOTE  = 8'h99;
	localparam logic [7:0] MASK_2B      = 8'hE0;
	localparam logic [7:0] LEAD_2B      = 8'hC0;
	localparam logic [7:0] MASK_3B      = 8'hF0;
	localparam logic [7:0] LEAD_3B      = 8'hE0;
	localparam logic [7:0] MASK_4B      = 8'hF8;
	localparam logic [7:0] LEAD_4B      = 8'hF0;

	localparam logic [6:0] CHAR_DOT     = 7'h2E;
	localparam logic [6:0] CHAR_DASH    = 7'h2D;
	localparam logic [6:0] CHAR_APOS    = 7'h27;

	// punct_match codes
	localparam logic [1:0] PM_NONE      = 2'd0;
	localparam logic [1:0] PM_LEAD      = 2'd1;
	localparam logic [1:0] PM_MID       = 2'd2;

	localparam logic [CNT_W-1:0] CAPACITY_RST = 10'd511;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [6:0]       out_char;
		logic             char_valid;
		logic             end_of_string;
		logic [CNT_W-1:0] char_count;
	} out_t;

	// One decoded byte: a run of identical characters plus an optional end record
	typedef struct packed {
		logic [1:0]       n_chars;
		logic [6:0]       ch;
		logic [CNT_W-1:0] first_cnt;
		logic             eos;
	} burst_t;

	typedef struct packed {
		logic [1:0]       skip_left;
		logic [1:0]       punct_match;
		logic [CNT_W-1:0] written;
	} dec_state_t;

endpackage

`default_nettype wire

// ----- hdl/utf8a_decode.sv -----
// Byte decoder: sequence tracking state and the per-byte result burst.
// Depends on utf8a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8a_decode import utf8a_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire in_t              item,
	input  wire logic [CNT_W-1:0] cap,
	output burst_t                burst,
	output dec_state_t            state
);

	logic [1:0]       skip_q, skip_d;
	logic [1:0]       pm_q, pm_d;
	logic [CNT_W-1:0] written_q, written_d;
	logic [1:0]       n;
	logic [6:0]       ch;
	logic [CNT_W:0]   room3;
	logic             has_room;
	logic [7:0]       b;

	assign b        = item.in_byte;
	assign has_room = written_q < cap;
	assign room3    = {1'b0, written_q} + (CNT_W+1)'(3);

	always_comb begin
		skip_d = skip_q;
		pm_d   = PM_NONE;
		n      = 2'd0;
		ch     = 7'd0;
		if (skip_q != 2'd0) begin
			if (skip_q == 2'd2 && pm_q == PM_LEAD) begin
				pm_d = (b == MID_PUNCT) ? PM_MID : PM_NONE;
			end else if (skip_q == 2'd1 && pm_q == PM_MID) begin
				if (b == TAIL_ELLIPS) begin
					ch = CHAR_DOT;
					if (room3 <= {1'b0, cap}) n = 2'd3;
				end else if (b == TAIL_EN || b == TAIL_EM) begin
					ch = CHAR_DASH;
					if (has_room) n = 2'd1;
				end else if (b == TAIL_LQUOTE || b == TAIL_RQUOTE) begin
					ch = CHAR_APOS;
					if (has_room) n = 2'd1;
				end
			end
			skip_d = skip_q - 2'd1;
		end else if (!b[7]) begin
			ch = b[6:0];
			if (has_room) n = 2'd1;
		end else if ((b & MASK_2B) == LEAD_2B) begin
			skip_d = 2'd1;
		end else if ((b & MASK_3B) == LEAD_3B) begin
			skip_d = 2'd2;
			pm_d   = (b == LEAD_PUNCT) ? PM_LEAD : PM_NONE;
		end else if ((b & MASK_4B) == LEAD_4B) begin
			skip_d = 2'd3;
		end
		written_d = written_q + CNT_W'(n);
		if (item.in_last) begin
			skip_d    = 2'd0;
			pm_d      = PM_NONE;
			written_d = '0;
		end
	end

	assign burst.n_chars   = n;
	assign burst.ch        = ch;
	assign burst.first_cnt = (n != 2'd0) ? written_q + CNT_W'(1) : written_q;
	assign burst.eos       = item.in_last;

	assign state.skip_left   = skip_q;
	assign state.punct_match = pm_q;
	assign state.written     = written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q    <= 2'd0;
			pm_q      <= PM_NONE;
			written_q <= '0;
		end else if (advance) begin
			skip_q    <= skip_d;
			pm_q      <= pm_d;
			written_q <= written_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/utf8a_emit.sv -----
// Result register: holds one decoded burst and hands out one result per transfer.
// Depends on utf8a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8a_emit import utf8a_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire burst_t burst,
	output logic        free,
	output logic        out_valid,
	input  wire logic   out_stall,
	output out_t        out_data
);

	logic [1:0]       left_q;
	logic             end_q;
	logic [6:0]       char_q;
	logic [CNT_W-1:0] cnt_q;
	logic             xfer;
	logic             finishing;

	assign out_valid = (left_q != 2'd0) || end_q;
	assign xfer      = out_valid && !out_stall;
	assign finishing = (left_q == 2'd1 && !end_q) || (left_q == 2'd0 && end_q);
	assign free      = !out_valid || (xfer && finishing);

	always_comb begin
		if (left_q != 2'd0) begin
			out_data.out_char      = char_q;
			out_data.char_valid    = 1'b1;
			out_data.end_of_string = 1'b0;
		end else begin
			out_data.out_char      = 7'd0;
			out_data.char_valid    = 1'b0;
			out_data.end_of_string = 1'b1;
		end
		out_data.char_count = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
			end_q  <= 1'b0;
		end else if (load) begin
			left_q <= burst.n_chars;
			end_q  <= burst.eos;
		end else if (xfer) begin
			if (left_q != 2'd0) left_q <= left_q - 2'd1;
			else end_q <= 1'b0;
		end
	end

	// End record reuses the count of the last character
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= burst.ch;
			cnt_q  <= burst.first_cnt;
		end else if (xfer && left_q > 2'd1) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/utf8_to_ascii_filter.sv -----
// Top level of the UTF-8 to ASCII filter: input register, capacity register, assertions.
// Depends on utf8a_pkg, utf8a_decode and utf8a_emit.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    in_data  (in_t)
//   out      source     out_valid / out_stall  out_data (out_t)
//   cfg      sink       cfg_wr_en              cfg_wr_data (capacity)
//
// One byte per cycle leaves the input register while the result register is free.
// A byte that writes nothing retires even while results wait.
// A byte with k results occupies the result register for k transfers (up to 4,
// three dots plus an end record); the input register holds until it drains.
// Reset clears the sequence state and the character count; capacity resets to 511.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_ascii_filter import utf8a_pkg::*; #(
	parameter int MAX_CAPACITY = 1023
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_t                  out_data,
	input  wire logic             cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data
);

	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] cap_eff;
	logic             valid_s1;
	in_t              item_s1;
	logic             in_xfer;
	logic             advance;
	logic             load;
	logic             free;
	burst_t           burst;
	dec_state_t       dstate;

	assign cap_eff = (32'(capacity_q) > 32'(MAX_CAPACITY)) ? CNT_W'(MAX_CAPACITY)
	                                                       : capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// Bytes with no result never wait on the output side
	assign load     = valid_s1 && free && (burst.n_chars != 2'd0 || burst.eos);
	assign advance  = valid_s1 && (free || (burst.n_chars == 2'd0 && !burst.eos));
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) item_s1 <= in_data;
	end

	utf8a_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.cap    (cap_eff),
		.burst  (burst),
		.state  (dstate)
	);

	utf8a_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.free     (free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted byte did not reach the input register");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register overwritten before it drained");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.in_last) |=>
			(dstate.skip_left == 2'd0 && dstate.punct_match == PM_NONE &&
			 dstate.written == '0))
		else $error("state not cleared after last byte");

endmodule

`default_nettype wire
